@@ hw/rtl/ias_pkg.sv @@
// ias_pkg: shared constants and types of the interval activity selector
// no dependencies; used by ias_front, ias_back and interval_activity_selector
`timescale 1ns / 1ps

package ias_pkg;

   localparam int MAX_INTERVALS_DEF = 64;
   localparam int TIME_BITS_DEF     = 16;
   localparam int INDEX_BITS        = 7;
   localparam int LINK_DEPTH        = 4;

   // control of the link between front and back
   typedef struct packed {
      logic avail;
      logic last_item;
   } link_ctl_type;

   // back end sequencer
   typedef enum logic [4:0] {
      ST_LOAD  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_PICK  = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_CLEAR = 5'b10000
   } back_state_type;

endpackage

@@ hw/rtl/ias_front.sv @@
// ias_front: input acceptance and short queue towards the back end
// depends on ias_pkg
`timescale 1ns / 1ps

module ias_front #(
   parameter int TIME_BITS = ias_pkg::TIME_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [TIME_BITS-1:0]    req_start_time,
   input  logic [TIME_BITS-1:0]    req_finish_time,
   input  logic                    req_last_item,
   output ias_pkg::link_ctl_type   link_ctl,
   output logic [TIME_BITS-1:0]    link_start,
   output logic [TIME_BITS-1:0]    link_finish,
   input  logic                    link_take
);

   localparam int PTR_W = $clog2(ias_pkg::LINK_DEPTH);
   localparam int CNT_W = $clog2(ias_pkg::LINK_DEPTH + 1);

   logic [TIME_BITS-1:0] s_mem_ff [ias_pkg::LINK_DEPTH];
   logic [TIME_BITS-1:0] f_mem_ff [ias_pkg::LINK_DEPTH];
   logic                 l_mem_ff [ias_pkg::LINK_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 push_ok, take_ok;

   // transfer qualifiers
   assign req_full = (count_ff == CNT_W'(ias_pkg::LINK_DEPTH));
   assign push_ok  = req_push && !req_full;
   assign take_ok  = link_take && (count_ff != '0);

   // queue head towards the back end
   assign link_ctl.avail     = (count_ff != '0);
   assign link_ctl.last_item = l_mem_ff[rd_ptr_ff];
   assign link_start         = s_mem_ff[rd_ptr_ff];
   assign link_finish        = f_mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !take_ok) begin
         count_in = count_ff + 1'b1;
      end else if (!push_ok && take_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         s_mem_ff[wr_ptr_ff] <= req_start_time;
         f_mem_ff[wr_ptr_ff] <= req_finish_time;
         l_mem_ff[wr_ptr_ff] <= req_last_item;
      end
   end

   // fill count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ias_pkg::LINK_DEPTH))
      else $error("link queue count out of range");

   // a full queue with no take keeps its count
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (req_full && !link_take) |=> req_full)
      else $error("link queue lost an entry");

   // a take empties one slot
   a_take_count: assert property (@(posedge clock) disable iff (reset)
      (take_ok && !push_ok) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("link queue count slip");

endmodule

@@ hw/rtl/ias_back.sv @@
// ias_back: interval storage, greedy earliest finish selection and result output
// depends on ias_pkg
`timescale 1ns / 1ps

module ias_back #(
   parameter int MAX_INTERVALS = ias_pkg::MAX_INTERVALS_DEF,
   parameter int TIME_BITS     = ias_pkg::TIME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ias_pkg::link_ctl_type             link_ctl,
   input  logic [TIME_BITS-1:0]              link_start,
   input  logic [TIME_BITS-1:0]              link_finish,
   output logic                              link_take,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [ias_pkg::INDEX_BITS-1:0]    rsp_chosen_index,
   output logic                              rsp_end_of_run,
   output logic                              rsp_overflow
);

   localparam int IDX_W = $clog2(MAX_INTERVALS);
   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

   logic [TIME_BITS-1:0] start_mem [MAX_INTERVALS];
   logic [TIME_BITS-1:0] finish_mem [MAX_INTERVALS];
   logic [TIME_BITS-1:0] rd_start_ff, rd_finish_ff;

   ias_pkg::back_state_type state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic [CNT_W-1:0]     addr_ff, addr_in;
   logic                 rd_v_ff, rd_v_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 first_ff, first_in;
   logic [TIME_BITS-1:0] lf_ff, lf_in;
   logic [IDX_W-1:0]     cur_idx_ff, cur_idx_in;
   logic                 best_v_ff, best_v_in;
   logic [TIME_BITS-1:0] best_f_ff, best_f_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [MAX_INTERVALS-1:0] map_ff, map_in;
   logic                 prev_v_ff, prev_v_in;
   logic [IDX_W-1:0]     prev_ff, prev_in;
   logic                 out_v_ff, out_v_in;
   logic [ias_pkg::INDEX_BITS-1:0] out_idx_ff, out_idx_in;
   logic                 out_eor_ff, out_eor_in;

   logic wr_en, rd_en, slot_free, cand, better, in_range;

   assign rsp_empty        = !out_v_ff;
   assign rsp_chosen_index = out_idx_ff;
   assign rsp_end_of_run   = out_eor_ff;
   assign rsp_overflow     = ovf_ff;
   assign slot_free        = !out_v_ff || rsp_pop;
   assign in_range         = (addr_ff < count_ff);

   // store write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[count_ff[IDX_W-1:0]]  <= link_start;
         finish_mem[count_ff[IDX_W-1:0]] <= link_finish;
      end
      if (rd_en) begin
         rd_start_ff  <= start_mem[addr_ff[IDX_W-1:0]];
         rd_finish_ff <= finish_mem[addr_ff[IDX_W-1:0]];
      end
   end

   // candidate test: after the last pick in finish order and starting past it
   always_comb begin
      cand = first_ff ||
             ((rd_start_ff > lf_ff) &&
              ((rd_finish_ff > lf_ff) ||
               ((rd_finish_ff == lf_ff) && (rd_idx_ff > cur_idx_ff))));
      better = !best_v_ff || (rd_finish_ff < best_f_ff);
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      addr_in     = addr_ff;
      rd_v_in     = 1'b0;
      rd_idx_in   = addr_ff[IDX_W-1:0];
      first_in    = first_ff;
      lf_in       = lf_ff;
      cur_idx_in  = cur_idx_ff;
      best_v_in   = best_v_ff;
      best_f_in   = best_f_ff;
      best_idx_in = best_idx_ff;
      map_in      = map_ff;
      prev_v_in   = prev_v_ff;
      prev_in     = prev_ff;
      out_v_in    = rsp_pop ? 1'b0 : out_v_ff;
      out_idx_in  = out_idx_ff;
      out_eor_in  = out_eor_ff;
      link_take   = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      case (state_ff)
         ias_pkg::ST_LOAD: begin
            if (link_ctl.avail) begin
               link_take = 1'b1;
               if (count_ff < CNT_W'(MAX_INTERVALS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (link_ctl.last_item) begin
                  state_in  = ias_pkg::ST_SCAN;
                  first_in  = 1'b1;
                  best_v_in = 1'b0;
                  addr_in   = '0;
               end
            end
         end
         ias_pkg::ST_SCAN: begin
            // one read issued a cycle, compared in the following cycle
            if (in_range) begin
               rd_en   = 1'b1;
               rd_v_in = 1'b1;
               addr_in = addr_ff + 1'b1;
            end
            if (rd_v_ff && cand && better) begin
               best_v_in   = 1'b1;
               best_f_in   = rd_finish_ff;
               best_idx_in = rd_idx_ff;
            end
            if (!in_range && !rd_v_ff) begin
               state_in = ias_pkg::ST_PICK;
            end
         end
         ias_pkg::ST_PICK: begin
            addr_in = '0;
            if (best_v_ff) begin
               map_in[best_idx_ff] = 1'b1;
               lf_in      = best_f_ff;
               cur_idx_in = best_idx_ff;
               first_in   = 1'b0;
               best_v_in  = 1'b0;
               state_in   = ias_pkg::ST_SCAN;
            end else begin
               prev_v_in = 1'b0;
               state_in  = ias_pkg::ST_EMIT;
            end
         end
         ias_pkg::ST_EMIT: begin
            // hold one index back so the final one can be marked
            if (in_range) begin
               if (!map_ff[addr_ff[IDX_W-1:0]]) begin
                  addr_in = addr_ff + 1'b1;
               end else if (!prev_v_ff) begin
                  prev_v_in = 1'b1;
                  prev_in   = addr_ff[IDX_W-1:0];
                  addr_in   = addr_ff + 1'b1;
               end else if (slot_free) begin
                  out_v_in   = 1'b1;
                  out_idx_in = ias_pkg::INDEX_BITS'(prev_ff) + 1'b1;
                  out_eor_in = 1'b0;
                  prev_in    = addr_ff[IDX_W-1:0];
                  addr_in    = addr_ff + 1'b1;
               end
            end else if (slot_free) begin
               out_v_in   = 1'b1;
               out_idx_in = ias_pkg::INDEX_BITS'(prev_ff) + 1'b1;
               out_eor_in = 1'b1;
               state_in   = ias_pkg::ST_CLEAR;
            end
         end
         ias_pkg::ST_CLEAR: begin
            // overflow flag stays until the final result is taken
            if (slot_free) begin
               count_in = '0;
               map_in   = '0;
               lf_in    = '0;
               ovf_in   = 1'b0;
               state_in = ias_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = ias_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ias_pkg::ST_LOAD;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         rd_v_ff   <= 1'b0;
         map_ff    <= '0;
         lf_ff     <= '0;
         best_v_ff <= 1'b0;
         first_ff  <= 1'b1;
         prev_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
         addr_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         rd_v_ff   <= rd_v_in;
         map_ff    <= map_in;
         lf_ff     <= lf_in;
         best_v_ff <= best_v_in;
         first_ff  <= first_in;
         prev_v_ff <= prev_v_in;
         out_v_ff  <= out_v_in;
         addr_ff   <= addr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      cur_idx_ff  <= cur_idx_in;
      best_f_ff   <= best_f_in;
      best_idx_ff <= best_idx_in;
      prev_ff     <= prev_in;
      out_idx_ff  <= out_idx_in;
      out_eor_ff  <= out_eor_in;
   end

   // interval count never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_INTERVALS))
      else $error("interval count out of range");

   // selection map is empty while loading
   a_map_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ias_pkg::ST_LOAD) |-> (map_ff == '0))
      else $error("selection map not cleared");

   // a pick marks its interval
   a_pick_marks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ias_pkg::ST_PICK && best_v_ff) |=> map_ff[$past(best_idx_ff)])
      else $error("picked interval not marked");

   // no transfer from the link outside loading
   a_take_load: assert property (@(posedge clock) disable iff (reset)
      link_take |-> (state_ff == ias_pkg::ST_LOAD))
      else $error("link taken outside loading");

endmodule

@@ hw/rtl/interval_activity_selector.sv @@
// interval_activity_selector: top level joining the input front and the selection back end
// depends on ias_pkg, ias_front, ias_back
`timescale 1ns / 1ps

// Intervals are pushed one per cycle while full is low as (start, finish, last) and pass
// a four entry queue into the interval store; the item marked last closes the set.
// Intervals past MAX_INTERVALS are dropped and flag overflow on every result of that
// set. Selection then runs with input stalled once the queue fills: each pick is one
// pass over the n stored intervals through the registered store read port, followed by
// a pick step, and a final pass that finds no candidate ends selection; the output pass
// then walks the selection map once more, stalling while the result side holds pop low.
// Results come out in ascending arrival index, the final one marked by end_of_run.
module interval_activity_selector #(
   parameter int MAX_INTERVALS = ias_pkg::MAX_INTERVALS_DEF,
   parameter int TIME_BITS     = ias_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [TIME_BITS-1:0]           req_start_time,
   input  logic [TIME_BITS-1:0]           req_finish_time,
   input  logic                           req_last_item,
   output logic                           empty,
   input  logic                           pop,
   output logic [ias_pkg::INDEX_BITS-1:0] rsp_chosen_index,
   output logic                           rsp_end_of_run,
   output logic                           rsp_overflow
);

   ias_pkg::link_ctl_type link_ctl;
   logic [TIME_BITS-1:0]  link_start, link_finish;
   logic                  link_take;

   // input side
   ias_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (push),
      .req_full        (full),
      .req_start_time  (req_start_time),
      .req_finish_time (req_finish_time),
      .req_last_item   (req_last_item),
      .link_ctl        (link_ctl),
      .link_start      (link_start),
      .link_finish     (link_finish),
      .link_take       (link_take)
   );

   // storage, selection and result side
   ias_back #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .TIME_BITS     (TIME_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .link_ctl         (link_ctl),
      .link_start       (link_start),
      .link_finish      (link_finish),
      .link_take        (link_take),
      .rsp_empty        (empty),
      .rsp_pop          (pop),
      .rsp_chosen_index (rsp_chosen_index),
      .rsp_end_of_run   (rsp_end_of_run),
      .rsp_overflow     (rsp_overflow)
   );

endmodule
